>>> design/kvhd_pkg.sv
// Package: codes, widths and types shared by the header frame deframer.
`timescale 1ns / 1ps

package kvhd_pkg;

    localparam int ByteW     = 8;
    localparam int KindW     = 3;
    localparam int ErrW      = 2;
    localparam int FrameLenW = 32;
    localparam int LenBytes  = 4;
    localparam int LenIdxW   = 2;

    localparam logic [ByteW-1:0] TermByte = 8'hFF;

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_KLEN = 3'd1,
        PH_STR  = 3'd2,
        PH_VLEN = 3'd3,
        PH_PAY  = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    typedef logic [KindW-1:0] t_kind;
    typedef logic [ErrW-1:0]  t_err;

    localparam t_kind KIND_LEN  = 3'd0;
    localparam t_kind KIND_KLEN = 3'd1;
    localparam t_kind KIND_KEY  = 3'd2;
    localparam t_kind KIND_VLEN = 3'd3;
    localparam t_kind KIND_VAL  = 3'd4;
    localparam t_kind KIND_TERM = 3'd5;
    localparam t_kind KIND_PAY  = 3'd6;
    localparam t_kind KIND_SKIP = 3'd7;

    localparam t_err ERR_NONE    = 2'd0;
    localparam t_err ERR_OVERRUN = 2'd1;
    localparam t_err ERR_EMPTY   = 2'd2;

endpackage

>>> design/kvhd_if.sv
// Interfaces: input byte channel and tagged byte result channel.
`timescale 1ns / 1ps

interface kvhd_in_if;
    import kvhd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface kvhd_out_if;
    import kvhd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_byte;
    t_kind            byte_kind;
    logic             frame_last;
    t_err             error_code;

    modport source (output valid, output out_byte, output byte_kind, output frame_last,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input frame_last,
                    input error_code, output ready);
endinterface

>>> design/kv_header_frame_deframer_core.sv
// Top level: key/value header frame deframer that tags every stream byte.
// Usage:
//   i_in  carries raw stream bytes (valid/ready, item moves when both high).
//   o_out carries one tagged item per input item: the byte, its kind,
//         a frame-last flag and an error code on the byte that detects it.
//   Each frame is a 4-byte big-endian body length, then header entries
//   (key length, key, value length, value), a 0xFF terminator and payload.
//   After an error the rest of the frame body is tagged skipped.
// Timing:
//   The result is registered: it is valid in the cycle after input accept.
//   Throughput is one item per cycle while o_out.ready stays high; the per-byte
//   state update (a 32-bit compare and decrement of the remaining body count)
//   sits between the input handshake and the result register.
// Reset:
//   i_rst_n low synchronously returns to the length phase and empties the
//   result register.
// Stall:
//   While the receiver holds o_out.ready low with a result waiting, the
//   result holds and i_in.ready drops; the waiting result and a new input
//   item move in the same cycle once the receiver takes it.
`timescale 1ns / 1ps

module kv_header_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvhd_in_if.sink    i_in,
    kvhd_out_if.source o_out
);
    import kvhd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [LenIdxW-1:0]    r_len_idx, n_len_idx;
    logic [FrameLenW-1:0]  r_frame_rem, n_frame_rem;
    logic [ByteW-1:0]      r_str_rem, n_str_rem;
    logic                  r_in_value, n_in_value;

    logic                  r_out_valid;
    logic [ByteW-1:0]      r_out_byte;
    t_kind                 r_out_kind, n_kind;
    logic                  r_out_last, n_last;
    t_err                  r_out_err, n_err;

    logic                  in_accept;
    logic [ByteW-1:0]      b;
    logic [FrameLenW-1:0]  b_wide;

    assign b         = i_in.in_byte;
    assign b_wide    = {{(FrameLenW-ByteW){1'b0}}, b};
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept = i_in.valid && i_in.ready;

    always_comb begin
        n_phase     = r_phase;
        n_len_idx   = r_len_idx;
        n_frame_rem = r_frame_rem;
        n_str_rem   = r_str_rem;
        n_in_value  = r_in_value;
        n_kind      = KIND_SKIP;
        n_last      = 1'b0;
        n_err       = ERR_NONE;

        if (r_phase == PH_LEN) begin
            n_kind      = KIND_LEN;
            n_frame_rem = {r_frame_rem[FrameLenW-ByteW-1:0], b};
            n_len_idx   = r_len_idx + 1'b1;
            if (r_len_idx == LenIdxW'(LenBytes - 1)) begin
                if (n_frame_rem == '0) begin
                    n_err   = ERR_EMPTY;
                    n_last  = 1'b1;
                    n_phase = PH_LEN;
                end else begin
                    n_phase    = PH_KLEN;
                    n_in_value = 1'b0;
                end
            end
        end else begin
            case (r_phase)
                PH_KLEN, PH_VLEN: begin
                    if (r_phase == PH_KLEN && b == TermByte) begin
                        n_kind  = KIND_TERM;
                        n_phase = PH_PAY;
                    end else begin
                        n_kind     = (r_phase == PH_KLEN) ? KIND_KLEN : KIND_VLEN;
                        n_in_value = (r_phase == PH_VLEN);
                        if (r_frame_rem < FrameLenW'(2)
                            || b_wide > (r_frame_rem - FrameLenW'(2))) begin
                            n_err   = ERR_OVERRUN;
                            n_phase = PH_SKIP;
                        end else if (b == '0) begin
                            n_phase = n_in_value ? PH_KLEN : PH_VLEN;
                        end else begin
                            n_str_rem = b;
                            n_phase   = PH_STR;
                        end
                    end
                end
                PH_STR: begin
                    n_kind    = r_in_value ? KIND_VAL : KIND_KEY;
                    n_str_rem = r_str_rem - 1'b1;
                    if (n_str_rem == '0) begin
                        n_phase = r_in_value ? PH_KLEN : PH_VLEN;
                    end
                end
                PH_PAY: begin
                    n_kind = KIND_PAY;
                end
                default: begin
                    n_kind  = KIND_SKIP;
                    n_phase = PH_SKIP;
                end
            endcase
            n_frame_rem = r_frame_rem - 1'b1;
            if (n_frame_rem == '0) begin
                n_last     = 1'b1;
                n_phase    = PH_LEN;
                n_len_idx  = '0;
                n_str_rem  = '0;
                n_in_value = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_len_idx   <= '0;
            r_frame_rem <= '0;
            r_str_rem   <= '0;
            r_in_value  <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_len_idx   <= n_len_idx;
            r_frame_rem <= n_frame_rem;
            r_str_rem   <= n_str_rem;
            r_in_value  <= n_in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte <= b;
            r_out_kind <= n_kind;
            r_out_last <= n_last;
            r_out_err  <= n_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.byte_kind  = r_out_kind;
    assign o_out.frame_last = r_out_last;
    assign o_out.error_code = r_out_err;

`ifndef SYNTH
    a_len_phase_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEN |-> r_str_rem == '0 && !r_in_value)
        else $error("string state not cleared in length phase");

    a_empty_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err == ERR_EMPTY |-> r_out_last && r_out_kind == KIND_LEN
            && r_phase == PH_LEN)
        else $error("empty frame error without frame end");

    a_overrun_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_err == ERR_OVERRUN |=> r_phase == PH_SKIP || r_phase == PH_LEN)
        else $error("overrun did not enter skip");
`endif

endmodule

>>> dv/kv_header_frame_deframer_core_tb.sv
// Testbench for the header frame deframer: directed frames, then predicted random frames.
`timescale 1ns / 1ps

module kv_header_frame_deframer_core_tb;
    import kvhd_pkg::*;

    localparam int NumDirRows     = 27;
    localparam int NumRandomItems = 1750;
    localparam int CycleLimit     = 500000;
    localparam int DrainCycles    = 4;
    localparam int LongHold       = 150;
    localparam int MaxIdle        = 18;
    localparam int MaxPrint       = 40;
    localparam int HoldFrame      = 20;
    localparam int PauseFrame     = 45;

    typedef struct packed {
        logic [ByteW-1:0] data;
        t_kind            kind;
        logic             last;
        t_err             err;
    } byte_tag_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             typed;
        t_kind            kind;
        logic             last;
        t_err             err;
    } stim_row_t;

    logic clk;
    logic rst_n;

    kvhd_in_if  in_ch ();
    kvhd_out_if out_ch ();

    kv_header_frame_deframer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    byte_tag_t        expected_tags [$];
    logic [ByteW-1:0] frame_bytes [$];
    int               err_cnt        = 0;
    int               cycle_cnt      = 0;
    int               sent_cnt       = 0;
    int               tx_idle_max    = 0;
    int               rx_idle_max    = 0;
    int               rx_hold_cycles = 0;

    t_phase               ph;
    logic [LenIdxW-1:0]   len_idx;
    logic [FrameLenW-1:0] frame_rem;
    logic [ByteW-1:0]     str_rem;
    logic                 in_val;

    stim_row_t dir_rows [NumDirRows] = '{
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b1, ERR_EMPTY},
        '{8'h00, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h07, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h01, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h41, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h01, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h80, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'hFF, 1'b0, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h03, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h02, 1'b1, KIND_KLEN, 1'b0, ERR_OVERRUN},
        '{8'hE0, 1'b1, KIND_SKIP, 1'b0, ERR_NONE},
        '{8'hFF, 1'b1, KIND_SKIP, 1'b1, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h00, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h01, 1'b1, KIND_LEN,  1'b0, ERR_NONE},
        '{8'h05, 1'b1, KIND_KLEN, 1'b1, ERR_OVERRUN}
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CycleLimit);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic byte_tag_t tag_byte(input logic [ByteW-1:0] b);
        byte_tag_t            t;
        logic [FrameLenW-1:0] r;
        logic [FrameLenW-1:0] bw;
        t.data = b;
        t.kind = KIND_SKIP;
        t.last = 1'b0;
        t.err  = ERR_NONE;
        bw     = {{(FrameLenW-ByteW){1'b0}}, b};
        if (ph == PH_LEN) begin
            t.kind    = KIND_LEN;
            frame_rem = {frame_rem[FrameLenW-ByteW-1:0], b};
            len_idx   = len_idx + 1'b1;
            if (len_idx == '0) begin
                if (frame_rem == '0) begin
                    t.err  = ERR_EMPTY;
                    t.last = 1'b1;
                end else begin
                    ph     = PH_KLEN;
                    in_val = 1'b0;
                end
            end
        end else begin
            r = frame_rem;
            case (ph)
                PH_KLEN, PH_VLEN: begin
                    if (ph == PH_KLEN && b == TermByte) begin
                        t.kind = KIND_TERM;
                        ph     = PH_PAY;
                    end else begin
                        t.kind = (ph == PH_KLEN) ? KIND_KLEN : KIND_VLEN;
                        in_val = (ph == PH_VLEN);
                        if (r < 2 || bw > r - 2) begin
                            t.err = ERR_OVERRUN;
                            ph    = PH_SKIP;
                        end else if (b == '0) begin
                            ph = in_val ? PH_KLEN : PH_VLEN;
                        end else begin
                            str_rem = b;
                            ph      = PH_STR;
                        end
                    end
                end
                PH_STR: begin
                    t.kind  = in_val ? KIND_VAL : KIND_KEY;
                    str_rem = str_rem - 1'b1;
                    if (str_rem == '0) ph = in_val ? PH_KLEN : PH_VLEN;
                end
                PH_PAY: t.kind = KIND_PAY;
                default: begin
                    t.kind = KIND_SKIP;
                    ph     = PH_SKIP;
                end
            endcase
            frame_rem = r - 1;
            if (frame_rem == '0) begin
                t.last  = 1'b1;
                ph      = PH_LEN;
                len_idx = '0;
                str_rem = '0;
                in_val  = 1'b0;
            end
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < MaxPrint)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                             input byte_tag_t typed_tag);
        int        gap;
        byte_tag_t predicted;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        predicted = tag_byte(b);
        expected_tags.push_back(typed ? typed_tag : predicted);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic build_frame();
        logic [ByteW-1:0]     body [$];
        logic [FrameLenW-1:0] blen;
        int                   sel;
        int                   slen;
        int                   pos;
        body = {};
        sel  = $urandom_range(0, 99);
        if (sel < 8) begin
            repeat ($urandom_range(0, 24)) body.push_back(ByteW'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                for (int s = 0; s < 2; s++) begin
                    slen = ($urandom_range(0, 49) == 0) ? $urandom_range(5, 250)
                                                        : $urandom_range(0, 4);
                    body.push_back(ByteW'(slen));
                    repeat (slen) body.push_back(ByteW'($urandom_range(0, 255)));
                end
            end
            body.push_back(TermByte);
            repeat ($urandom_range(0, 6)) body.push_back(ByteW'($urandom_range(0, 255)));
            if (sel < 20) begin
                pos       = $urandom_range(0, body.size() - 1);
                body[pos] = ByteW'($urandom_range(0, 255));
            end
        end
        blen        = body.size();
        frame_bytes = {blen[31:24], blen[23:16], blen[15:8], blen[7:0]};
        foreach (body[i]) frame_bytes.push_back(body[i]);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return MaxIdle;
        endcase
    endfunction

    always @(posedge clk) begin
        byte_tag_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_tags.size() == 0) begin
                report_mismatch("unexpected result, byte", int'(out_ch.out_byte), 0);
            end else begin
                want = expected_tags.pop_front();
                if (out_ch.out_byte !== want.data)
                    report_mismatch("out_byte", int'(out_ch.out_byte), int'(want.data));
                if (out_ch.byte_kind !== want.kind)
                    report_mismatch("byte_kind", int'(out_ch.byte_kind), int'(want.kind));
                if (out_ch.frame_last !== want.last)
                    report_mismatch("frame_last", int'(out_ch.frame_last), int'(want.last));
                if (out_ch.error_code !== want.err)
                    report_mismatch("error_code", int'(out_ch.error_code), int'(want.err));
            end
        end
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall          = $urandom_range(0, rx_idle_max) + rx_hold_cycles;
            rx_hold_cycles = 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    initial begin
        byte_tag_t row_tag;
        int        frame_no;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        rst_n         = 1'b0;
        ph            = PH_LEN;
        len_idx       = '0;
        frame_rem     = '0;
        str_rem       = '0;
        in_val        = 1'b0;
        frame_no      = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_max = pick_idle();
        rx_idle_max = pick_idle();
        foreach (dir_rows[i]) begin
            row_tag = '{dir_rows[i].data, dir_rows[i].kind, dir_rows[i].last, dir_rows[i].err};
            send_byte(dir_rows[i].data, dir_rows[i].typed, row_tag);
        end
        in_ch.valid <= 1'b0;
        wait (expected_tags.size() == 0);
        @(negedge clk);

        while (sent_cnt < NumDirRows + NumRandomItems) begin
            frame_no++;
            tx_idle_max = pick_idle();
            rx_idle_max = pick_idle();
            if (frame_no == HoldFrame) begin
                rx_hold_cycles = LongHold;
                tx_idle_max    = 0;
            end
            if (frame_no == PauseFrame) begin
                in_ch.valid <= 1'b0;
                wait (expected_tags.size() == 0);
                @(negedge clk);
            end
            build_frame();
            foreach (frame_bytes[j]) send_byte(frame_bytes[j], 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        wait (expected_tags.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
